>>> sv/bel_pkg.sv
// Shared types, constants and helpers for the explicit bidi level resolver.
`default_nettype none

package bel_pkg;

	// Deepest explicit level and status stack size (base entry included)
	localparam int MAX_LEVEL   = 125;
	localparam int STACK_DEPTH = MAX_LEVEL + 2;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int LVL_W       = 7;
	localparam int CAT_W       = 5;
	localparam int OVF_W       = 16;
	localparam int VISO_W      = 7;

	localparam logic [LVL_W:0]    MAX_LEVEL_N = (LVL_W + 1)'(MAX_LEVEL);
	localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0]  CNT_ONE     = CNT_W'(1);
	localparam logic [OVF_W-1:0]  OVF_SAT     = '1;
	localparam logic [VISO_W-1:0] VISO_SAT    = '1;

	// Bidi class codes
	localparam logic [CAT_W-1:0] CAT_L   = 5'd0;
	localparam logic [CAT_W-1:0] CAT_R   = 5'd1;
	localparam logic [CAT_W-1:0] CAT_BN  = 5'd9;
	localparam logic [CAT_W-1:0] CAT_B   = 5'd10;
	localparam logic [CAT_W-1:0] CAT_LRE = 5'd14;
	localparam logic [CAT_W-1:0] CAT_LRO = 5'd15;
	localparam logic [CAT_W-1:0] CAT_RLE = 5'd16;
	localparam logic [CAT_W-1:0] CAT_RLO = 5'd17;
	localparam logic [CAT_W-1:0] CAT_PDF = 5'd18;
	localparam logic [CAT_W-1:0] CAT_LRI = 5'd19;
	localparam logic [CAT_W-1:0] CAT_RLI = 5'd20;
	localparam logic [CAT_W-1:0] CAT_FSI = 5'd21;
	localparam logic [CAT_W-1:0] CAT_PDI = 5'd22;

	// Override status codes
	localparam logic [1:0] OVR_NONE = 2'd0;
	localparam logic [1:0] OVR_LTR  = 2'd1;
	localparam logic [1:0] OVR_RTL  = 2'd2;

	// Register indexes
	localparam logic REG_PARA_LEVEL = 1'b0;
	localparam logic REG_NEWER      = 1'b1;
	localparam int   PADDR_W        = 3;

	typedef struct packed {
		logic [CAT_W-1:0] category;
		logic             fsi_is_rtl;
		logic             starts_paragraph;
	} in_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             level_assigned;
		logic [CAT_W-1:0] category_out;
	} out_t;

	// Status stack entry: isolate flag, override, level
	typedef struct packed {
		logic             iso;
		logic [1:0]       ovr;
		logic [LVL_W-1:0] level;
	} entry_t;

	typedef struct packed {
		logic paragraph_level;
		logic newer_rules;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load;       // take input transaction, start top-of-stack read
		logic rd;         // read top of stack
		logic commit;     // apply item and load result
		logic pdi_begin;  // PDI that unwinds the stack
		logic scan_pop;   // drop a non-isolate entry
		logic scan_last;  // drop the isolate entry and close the isolate
		logic pdi_emit;   // load PDI result after unwinding
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic pdi_pop;
		logic scan_more;
		logic out_free;
	} sts_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_SCAN_RD,
		ST_FIN_RD,
		ST_FIN
	} state_t;

	// Next odd or even level above lvl
	function automatic logic [LVL_W:0] next_level(input logic [LVL_W-1:0] lvl,
			input logic odd);
		logic [LVL_W:0] n;
		if (odd) begin
			n = ({1'b0, lvl} + (LVL_W + 1)'(1)) | (LVL_W + 1)'(1);
		end else begin
			n = ({1'b0, lvl} + (LVL_W + 1)'(2)) & ~(LVL_W + 1)'(1);
		end
		return n;
	endfunction

	// Override rewriting of a class
	function automatic logic [CAT_W-1:0] rewrite(input logic [CAT_W-1:0] cat,
			input logic [1:0] ovr);
		logic [CAT_W-1:0] r;
		r = cat;
		if (ovr == OVR_LTR) begin
			r = CAT_L;
		end else if (ovr == OVR_RTL) begin
			r = CAT_R;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/bel_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module bel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> sv/bel_regs.sv
// APB configuration registers of the explicit bidi level resolver.
`default_nettype none

module bel_regs import bel_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output cfg_t                    cfg
);

	logic para_level_q;
	logic newer_q;
	logic wr_stb;
	logic reg_idx;

	assign pready  = 1'b1;
	assign wr_stb  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[2];

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			para_level_q <= 1'b0;
			newer_q      <= 1'b1;
		end else if (wr_stb) begin
			unique case (reg_idx)
				REG_PARA_LEVEL: para_level_q <= pwdata[0];
				REG_NEWER:      newer_q      <= pwdata[0];
				default:        ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_PARA_LEVEL: prdata[0] = para_level_q;
			REG_NEWER:      prdata[0] = newer_q;
			default:        prdata    = '0;
		endcase
	end

	assign cfg.paragraph_level = para_level_q;
	assign cfg.newer_rules     = newer_q;

endmodule

`default_nettype wire

>>> sv/bel_ctrl.sv
// Sequencer for the explicit bidi level resolver.
`default_nettype none

module bel_ctrl import bel_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.rd   = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.pdi_pop) begin
					cmd.pdi_begin = 1'b1;
					state_d       = ST_SCAN;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_more) begin
					cmd.scan_pop = 1'b1;
					state_d      = ST_SCAN_RD;
				end else begin
					cmd.scan_last = 1'b1;
					state_d       = ST_FIN_RD;
				end
			end
			ST_SCAN_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_FIN_RD: begin
				cmd.rd  = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.pdi_emit = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// A fresh transaction always gets its top-of-stack read next
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_EXEC)
		else $error("accepted transaction did not reach execute");

	// Unwinding always ends with a read before the result goes out
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> $past(state_q) == ST_FIN_RD || $past(state_q) == ST_FIN)
		else $error("PDI result without fresh top of stack");

endmodule

`default_nettype wire

>>> sv/bel_dp.sv
// Datapath: status stack, counters, X1-X8 rules and result register.
`default_nettype none

module bel_dp import bel_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire in_t  in_data,
	input  wire cmd_t cmd,
	output sts_t      sts,
	output logic      out_valid,
	input  wire logic out_ready,
	output out_t      out_data
);

	in_t               in_q;
	out_t              out_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [OVF_W-1:0]  ovf_iso_q, ovf_iso_d;
	logic [OVF_W-1:0]  ovf_emb_q, ovf_emb_d;
	logic [VISO_W-1:0] viso_q, viso_d;

	logic              wr_en;
	entry_t            wr_ent;
	logic [9:0]        rd_raw;
	entry_t            top;
	entry_t            base;
	out_t              res;
	logic [LVL_W:0]    nlvl;
	logic              odd;
	logic              push_ok;
	logic              above_base;

	// Status stack storage, entry 0 is the implicit base
	bel_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(ADDR_W'(count_q)),
		.wr_data(wr_ent),
		.rd_en  (cmd.rd),
		.rd_addr(ADDR_W'(count_q - CNT_ONE)),
		.rd_data(rd_raw)
	);

	assign base.iso   = 1'b0;
	assign base.ovr   = OVR_NONE;
	assign base.level = LVL_W'(cfg.paragraph_level);

	assign above_base = count_q > CNT_ONE;
	assign top        = above_base ? entry_t'(rd_raw) : base;

	// Push candidate for embeddings and isolates
	always_comb begin
		odd = 1'b0;
		if (in_q.category == CAT_RLE || in_q.category == CAT_RLO ||
				in_q.category == CAT_RLI) begin
			odd = 1'b1;
		end else if (in_q.category == CAT_FSI) begin
			odd = in_q.fsi_is_rtl;
		end
	end

	assign nlvl    = next_level(top.level, odd);
	assign push_ok = nlvl <= MAX_LEVEL_N && ovf_iso_q == '0 && ovf_emb_q == '0 &&
		count_q < CNT_FULL;

	// Result and state update per class
	always_comb begin
		res.level          = '0;
		res.level_assigned = 1'b1;
		res.category_out   = in_q.category;
		count_d            = count_q;
		ovf_iso_d          = ovf_iso_q;
		ovf_emb_d          = ovf_emb_q;
		viso_d             = viso_q;
		wr_en              = 1'b0;
		wr_ent.level       = nlvl[LVL_W-1:0];
		wr_ent.ovr         = OVR_NONE;
		wr_ent.iso         = 1'b0;

		unique case (in_q.category)
			CAT_LRE, CAT_LRO, CAT_RLE, CAT_RLO: begin
				res.level_assigned = 1'b0;
				if (in_q.category == CAT_RLO) begin
					wr_ent.ovr = OVR_RTL;
				end else if (in_q.category == CAT_LRO) begin
					wr_ent.ovr = OVR_LTR;
				end
				if (push_ok) begin
					wr_en   = cmd.commit;
					count_d = count_q + CNT_ONE;
				end else if (ovf_iso_q == '0 && ovf_emb_q != OVF_SAT) begin
					ovf_emb_d = ovf_emb_q + OVF_W'(1);
				end
			end
			CAT_LRI, CAT_RLI, CAT_FSI: begin
				res.level  = top.level;
				wr_ent.iso = 1'b1;
				if (cfg.newer_rules) begin
					res.category_out = rewrite(in_q.category, top.ovr);
				end
				if (push_ok) begin
					wr_en   = cmd.commit;
					count_d = count_q + CNT_ONE;
					if (viso_q != VISO_SAT) begin
						viso_d = viso_q + VISO_W'(1);
					end
				end else if (ovf_iso_q != OVF_SAT) begin
					ovf_iso_d = ovf_iso_q + OVF_W'(1);
				end
			end
			CAT_PDI: begin
				// Matched isolates unwind through the scan states instead
				res.level = top.level;
				if (cfg.newer_rules) begin
					res.category_out = rewrite(in_q.category, top.ovr);
				end
				if (ovf_iso_q != '0) begin
					ovf_iso_d = ovf_iso_q - OVF_W'(1);
				end
			end
			CAT_PDF: begin
				res.level_assigned = 1'b0;
				if (ovf_iso_q != '0) begin
					ovf_iso_d = ovf_iso_q;
				end else if (ovf_emb_q != '0) begin
					ovf_emb_d = ovf_emb_q - OVF_W'(1);
				end else if (!top.iso && above_base) begin
					count_d = count_q - CNT_ONE;
				end
			end
			CAT_BN: begin
				res.level_assigned = 1'b0;
			end
			CAT_B: begin
				res.level = LVL_W'(cfg.paragraph_level);
			end
			default: begin
				res.level        = top.level;
				res.category_out = rewrite(in_q.category, top.ovr);
			end
		endcase
	end

	// Control state: stack pointer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= CNT_ONE;
			ovf_iso_q   <= '0;
			ovf_emb_q   <= '0;
			viso_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && in_data.starts_paragraph) begin
				count_q   <= CNT_ONE;
				ovf_iso_q <= '0;
				ovf_emb_q <= '0;
				viso_q    <= '0;
			end else if (cmd.commit) begin
				count_q   <= count_d;
				ovf_iso_q <= ovf_iso_d;
				ovf_emb_q <= ovf_emb_d;
				viso_q    <= viso_d;
			end else if (cmd.pdi_begin) begin
				ovf_emb_q <= '0;
			end else if (cmd.scan_pop) begin
				count_q <= count_q - CNT_ONE;
			end else if (cmd.scan_last) begin
				if (above_base) begin
					count_q <= count_q - CNT_ONE;
				end
				viso_q <= viso_q - VISO_W'(1);
			end

			if (cmd.commit || cmd.pdi_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.commit || cmd.pdi_emit) begin
			out_q <= res;
		end
	end

	assign sts.pdi_pop   = in_q.category == CAT_PDI && ovf_iso_q == '0 && viso_q != '0;
	assign sts.scan_more = above_base && !top.iso;
	assign sts.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Stack pointer stays within base entry and full depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNT_FULL)
		else $error("stack pointer out of range");

	// Pushes never land past the last stack slot
	assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> count_q < CNT_FULL)
		else $error("push into full stack");

	// A result is loaded only when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit || cmd.pdi_emit) |-> (!out_valid_q || out_ready))
		else $error("result overwrote pending transaction");

	// Unwinding only removes entries above the base
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_pop |-> count_q > CNT_ONE && viso_q != '0)
		else $error("PDI unwind past base entry");

endmodule

`default_nettype wire

>>> sv/bidi_explicit_level_resolver.sv
// Top level of the explicit bidi level resolver (rules X1 to X8).
//
// Channel   Direction  Handshake          Payload
// in        input      in_valid/in_ready  in_t: category, fsi_is_rtl, starts_paragraph
// out       output     out_valid/out_ready out_t: level, level_assigned, category_out
// cfg       APB        psel/penable/pready paragraph_level at 0x0, newer_rules at 0x4
//
// Most classes take a top-of-stack read from the stack RAM, then a step that
// applies the rule and loads the result register.
// A PDI closing a valid isolate removes stack entries one at a time, and each
// removal needs a fresh read through the single RAM read port.
// Reset clears the stack to its base entry and all counters; no clearing pass.
// A stalled result holds in the output register; the next transaction is taken
// meanwhile and waits in execute, or after unwinding for a PDI, until the register frees.
`default_nettype none

module bidi_explicit_level_resolver import bel_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire in_t                in_data,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output out_t                    out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	bel_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	bel_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bel_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_data  (in_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire
